>>> src/fjbs_pkg.sv
// fjbs_pkg: types and constants shared by the fair job batch selector
// no dependencies
package fjbs_pkg;

   localparam int LIM_W = 5;
   localparam int ID_W  = 32;

   localparam logic [1:0] CLS_ACTIVE    = 2'd0;
   localparam logic [1:0] CLS_PUBLISHED = 2'd1;
   localparam logic [1:0] CLS_DROP      = 2'd2;

   localparam logic [1:0] REG_GLOBAL_LIMIT = 2'd0;
   localparam logic [1:0] REG_OWNER_LIMIT  = 2'd1;
   localparam logic [1:0] REG_ORIGIN_LIMIT = 2'd2;

   localparam logic [3:0] ST_ABORTING  = 4'd5;
   localparam logic [3:0] ST_PUBLISHED = 4'd6;

   typedef struct packed {
      logic [LIM_W-1:0] global_limit;
      logic [LIM_W-1:0] per_owner_limit;
      logic [LIM_W-1:0] per_origin_limit;
   } cfg_type;

   typedef struct packed {
      logic [1:0]      cls;
      logic [ID_W-1:0] owner;
      logic [ID_W-1:0] origin;
      logic            last;
   } job_entry_type;

   typedef struct packed {
      logic [1:0]      cls;
      logic [ID_W-1:0] owner;
      logic [ID_W-1:0] origin;
   } job_rec_type;

   typedef struct packed {
      logic [LIM_W-1:0] usage;
      logic [ID_W-1:0]  owner;
   } owner_rec_type;

endpackage

>>> src/fair_job_batch_selector_core.sv
// fair_job_batch_selector_core: top level, configuration registers and channel packing
// depends on fjbs_pkg, fjbs_front, fjbs_queue, fjbs_back
//
// channel  signals                       direction  transfer
// req      req_tvalid/tready/tdata/tlast in         one job descriptor
// rsp      rsp_tvalid/tready/tdata/tuser out        one selected job
// csr      csr_valid/ready/index/data    in         one register write
//
// jobs are loaded into the job table, then a sequencer runs selection over it
// the owner list takes one job-table scan per entry built; each owner visit in a pass
// scans the job table for a job and checks its origin against every pick so far
// reset is synchronous; no clearing pass is needed
// a stalled rsp holds the engine only when a further result is ready to leave
module fair_job_batch_selector_core
   import fjbs_pkg::*;
#(
   parameter int MAX_JOBS   = 64,
   parameter int MAX_SELECT = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,   // job_state, owner_id, origin_id
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // job_index, sel_owner, sel_origin
   output logic [1:0]  rsp_tuser,   // none_selected, overflow
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [4:0]  csr_data
);

   cfg_type       cfg_ff, cfg_in;
   job_entry_type f_entry, q_entry;
   logic          f_valid, f_ready, q_valid, q_ready;
   logic [5:0]    r_index;
   logic [ID_W-1:0] r_owner, r_origin;
   logic          r_none, r_ovf;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_GLOBAL_LIMIT: cfg_in.global_limit     = csr_data;
            REG_OWNER_LIMIT:  cfg_in.per_owner_limit  = csr_data;
            REG_ORIGIN_LIMIT: cfg_in.per_origin_limit = csr_data;
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{global_limit: 5'd16, per_owner_limit: 5'd4, per_origin_limit: 5'd4};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   fjbs_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_state  (req_tdata[3:0]),
      .in_owner  (req_tdata[35:4]),
      .in_origin (req_tdata[67:36]),
      .in_last   (req_tlast),
      .out_valid (f_valid),
      .out_ready (f_ready),
      .out_entry (f_entry)
   );

   fjbs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (f_valid),
      .push_ready (f_ready),
      .push_entry (f_entry),
      .pop_valid  (q_valid),
      .pop_ready  (q_ready),
      .pop_entry  (q_entry)
   );

   fjbs_back #(
      .MAX_JOBS   (MAX_JOBS),
      .MAX_SELECT (MAX_SELECT)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .in_valid     (q_valid),
      .in_ready     (q_ready),
      .in_entry     (q_entry),
      .out_valid    (rsp_tvalid),
      .out_ready    (rsp_tready),
      .out_index    (r_index),
      .out_owner    (r_owner),
      .out_origin   (r_origin),
      .out_none     (r_none),
      .out_overflow (r_ovf),
      .out_last     (rsp_tlast)
   );

   assign rsp_tdata = {2'b00, r_origin, r_owner, r_index};
   assign rsp_tuser = {r_ovf, r_none};

endmodule

>>> src/fjbs_front.sv
// fjbs_front: input register stage, classifies the job state of each transfer
// depends on fjbs_pkg
module fjbs_front
   import fjbs_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   output logic          in_ready,
   input  logic [3:0]    in_state,
   input  logic [ID_W-1:0] in_owner,
   input  logic [ID_W-1:0] in_origin,
   input  logic          in_last,
   output logic          out_valid,
   input  logic          out_ready,
   output job_entry_type out_entry
);

   logic          valid_ff, valid_in;
   job_entry_type entry_ff, entry_in;
   logic [1:0]    cls;

   always_comb begin
      case (in_state) inside
         [4'd0:ST_ABORTING]: cls = CLS_ACTIVE;
         ST_PUBLISHED:       cls = CLS_PUBLISHED;
         default:            cls = CLS_DROP;
      endcase
   end

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      valid_in = valid_ff;
      entry_in = entry_ff;
      if (in_valid && in_ready) begin
         valid_in = 1'b1;
         entry_in = '{cls: cls, owner: in_owner, origin: in_origin, last: in_last};
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      entry_ff <= entry_in;
   end

   assign out_valid = valid_ff;
   assign out_entry = entry_ff;

endmodule

>>> src/fjbs_queue.sv
// fjbs_queue: two-entry queue between the classifying front and the selection engine
// depends on fjbs_pkg
module fjbs_queue
   import fjbs_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          push_valid,
   output logic          push_ready,
   input  job_entry_type push_entry,
   output logic          pop_valid,
   input  logic          pop_ready,
   output job_entry_type pop_entry
);

   job_entry_type slot_ff [2];
   logic       wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [1:0] fill_ff, fill_in;
   logic       do_push, do_pop;

   assign push_ready = fill_ff != 2'd2;
   assign pop_valid  = fill_ff != 2'd0;
   assign pop_entry  = slot_ff[rptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wptr_in = do_push ? !wptr_ff : wptr_ff;
      rptr_in = do_pop ? !rptr_ff : rptr_ff;
      fill_in = fill_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         fill_ff <= 2'd0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         fill_ff <= fill_in;
      end
      if (do_push) begin
         slot_ff[wptr_ff] <= push_entry;
      end
   end

endmodule

>>> src/fjbs_back.sv
// fjbs_back: job table, owner list build, round-robin selection passes and result register
// depends on fjbs_pkg
module fjbs_back
   import fjbs_pkg::*;
#(
   parameter int MAX_JOBS   = 64,
   parameter int MAX_SELECT = 16
) (
   input  logic          clock,
   input  logic          reset,
   input  cfg_type       cfg,
   input  logic          in_valid,
   output logic          in_ready,
   input  job_entry_type in_entry,
   output logic          out_valid,
   input  logic          out_ready,
   output logic [5:0]    out_index,
   output logic [ID_W-1:0] out_owner,
   output logic [ID_W-1:0] out_origin,
   output logic          out_none,
   output logic          out_overflow,
   output logic          out_last
);

   localparam int JIDX_W = $clog2(MAX_JOBS);
   localparam int CNT_W  = $clog2(MAX_JOBS + 1);
   localparam int SEL_W  = $clog2(MAX_SELECT + 1);
   localparam int PSW    = (MAX_SELECT > 1) ? $clog2(MAX_SELECT) : 1;

   typedef enum logic [14:0] {
      S_LOAD     = 15'b000000000000001,
      S_OB_START = 15'b000000000000010,
      S_OB_RD    = 15'b000000000000100,
      S_OB_EV    = 15'b000000000001000,
      S_MOD      = 15'b000000000010000,
      S_P_START  = 15'b000000000100000,
      S_OWN_RD   = 15'b000000001000000,
      S_OWN_EV   = 15'b000000010000000,
      S_J_RD     = 15'b000000100000000,
      S_J_EV     = 15'b000001000000000,
      S_O_RD     = 15'b000010000000000,
      S_O_EV     = 15'b000100000000000,
      S_PICK     = 15'b001000000000000,
      S_NEXT     = 15'b010000000000000,
      S_FINISH   = 15'b100000000000000
   } state_type;

   job_rec_type   job_mem   [MAX_JOBS];
   owner_rec_type owner_mem [MAX_JOBS];
   logic [ID_W-1:0] porg_mem [MAX_SELECT];
   job_rec_type     q_job;
   owner_rec_type   q_own;
   logic [ID_W-1:0] q_org;

   state_type state_ff, state_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in, nown_ff, nown_in, scan_ff, scan_in, i_ff, i_in;
   logic [JIDX_W-1:0] off_ff, off_in, rr_ff, rr_in, slot_ff, slot_in;
   logic [SEL_W-1:0]  sel_ff, sel_in, k_ff, k_in, ocnt_ff, ocnt_in, glim;
   logic              ovf_ff, ovf_in, prog_ff, prog_in, pub_ff, pub_in;
   logic              hprev_ff, hprev_in, bfound_ff, bfound_in;
   logic [ID_W-1:0]   prev_ff, prev_in, best_ff, best_in, cur_ff, cur_in;
   logic [ID_W-1:0]   corg_ff, corg_in, cown_ff, cown_in;
   logic [JIDX_W-1:0] cidx_ff, cidx_in;
   logic [MAX_JOBS-1:0] taken_ff, taken_in;
   logic              pend_ff, pend_in;
   logic [JIDX_W-1:0] pidx_ff, pidx_in;
   logic [ID_W-1:0]   pown_ff, pown_in, porg_ff, porg_in;
   logic              ov_ff, ov_in, onone_ff, onone_in, olast_ff, olast_in;
   logic              oovf_ff, oovf_in;
   logic [JIDX_W-1:0] oidx_ff, oidx_in;
   logic [ID_W-1:0]   oown_ff, oown_in, oorg_ff, oorg_in;
   logic              out_free;
   logic              jwe, owe, pwe;
   owner_rec_type     owd;
   logic [JIDX_W-1:0] owa;
   logic              match;

   assign out_free = !ov_ff || out_ready;
   assign in_ready = state_ff == S_LOAD;
   assign glim = SEL_W'((32'(cfg.global_limit) < MAX_SELECT) ? 32'(cfg.global_limit)
                                                              : MAX_SELECT);
   assign match = q_job.cls == (pub_ff ? CLS_PUBLISHED : CLS_ACTIVE)
                  && !taken_ff[scan_ff[JIDX_W-1:0]] && q_job.owner == cur_ff;

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;   nown_in = nown_ff; scan_in = scan_ff; i_in = i_ff;
      off_in = off_ff;   rr_in = rr_ff;     slot_in = slot_ff;
      sel_in = sel_ff;   k_in = k_ff;       ocnt_in = ocnt_ff;
      ovf_in = ovf_ff;   prog_in = prog_ff; pub_in = pub_ff;
      hprev_in = hprev_ff; bfound_in = bfound_ff;
      prev_in = prev_ff; best_in = best_ff; cur_in = cur_ff;
      corg_in = corg_ff; cown_in = cown_ff; cidx_in = cidx_ff;
      taken_in = taken_ff;
      pend_in = pend_ff; pidx_in = pidx_ff; pown_in = pown_ff; porg_in = porg_ff;
      ov_in = ov_ff && !out_ready;
      onone_in = onone_ff; olast_in = olast_ff; oovf_in = oovf_ff;
      oidx_in = oidx_ff; oown_in = oown_ff; oorg_in = oorg_ff;
      jwe = 1'b0; owe = 1'b0; pwe = 1'b0;
      owa = slot_ff;
      owd = '{usage: q_own.usage + LIM_W'(1), owner: cur_ff};
      case (state_ff)
         S_LOAD: begin
            if (in_valid) begin
               if (cnt_ff < CNT_W'(MAX_JOBS)) begin
                  jwe = 1'b1;
                  cnt_in = cnt_ff + CNT_W'(1);
               end else begin
                  ovf_in = 1'b1;
               end
               if (in_entry.last) begin
                  off_in = rr_ff;
                  state_in = S_OB_START;
               end
            end
         end
         S_OB_START: begin
            scan_in = '0;
            bfound_in = 1'b0;
            state_in = S_OB_RD;
         end
         S_OB_RD: state_in = S_OB_EV;
         S_OB_EV: begin
            if (scan_ff < cnt_ff) begin
               if (q_job.cls != CLS_DROP && (!hprev_ff || q_job.owner > prev_ff)
                   && (!bfound_ff || q_job.owner < best_ff)) begin
                  best_in = q_job.owner;
                  bfound_in = 1'b1;
               end
               scan_in = scan_ff + CNT_W'(1);
               state_in = S_OB_RD;
            end else if (bfound_ff) begin
               owe = 1'b1;
               owa = nown_ff[JIDX_W-1:0];
               owd = '{usage: '0, owner: best_ff};
               nown_in = nown_ff + CNT_W'(1);
               prev_in = best_ff;
               hprev_in = 1'b1;
               state_in = S_OB_START;
            end else begin
               state_in = S_MOD;
            end
         end
         S_MOD: begin
            if (nown_ff == '0) begin
               state_in = S_FINISH;
            end else if (CNT_W'(off_ff) >= nown_ff) begin
               off_in = off_ff - JIDX_W'(nown_ff);
            end else begin
               state_in = S_P_START;
            end
         end
         S_P_START: begin
            if (sel_ff >= glim) begin
               state_in = S_FINISH;
            end else begin
               i_in = '0;
               slot_in = off_ff;
               prog_in = 1'b0;
               state_in = S_OWN_RD;
            end
         end
         S_OWN_RD: state_in = S_OWN_EV;
         S_OWN_EV: begin
            if (q_own.usage >= cfg.per_owner_limit) begin
               state_in = S_NEXT;
            end else begin
               cur_in = q_own.owner;
               pub_in = 1'b0;
               scan_in = '0;
               state_in = S_J_RD;
            end
         end
         S_J_RD: state_in = S_J_EV;
         S_J_EV: begin
            if (scan_ff < cnt_ff) begin
               if (match) begin
                  corg_in = q_job.origin;
                  cown_in = q_job.owner;
                  cidx_in = scan_ff[JIDX_W-1:0];
                  k_in = '0;
                  ocnt_in = '0;
                  state_in = S_O_RD;
               end else begin
                  scan_in = scan_ff + CNT_W'(1);
                  state_in = S_J_RD;
               end
            end else if (!pub_ff) begin
               pub_in = 1'b1;
               scan_in = '0;
               state_in = S_J_RD;
            end else begin
               state_in = S_NEXT;
            end
         end
         S_O_RD: state_in = S_O_EV;
         S_O_EV: begin
            if (k_ff < sel_ff) begin
               if (q_org == corg_ff) begin
                  ocnt_in = ocnt_ff + SEL_W'(1);
               end
               k_in = k_ff + SEL_W'(1);
               state_in = S_O_RD;
            end else if (8'(ocnt_ff) < 8'(cfg.per_origin_limit)) begin
               state_in = S_PICK;
            end else begin
               scan_in = scan_ff + CNT_W'(1);
               state_in = S_J_RD;
            end
         end
         S_PICK: begin
            if (!pend_ff || out_free) begin
               if (pend_ff) begin
                  ov_in = 1'b1;
                  onone_in = 1'b0;
                  olast_in = 1'b0;
                  oovf_in = ovf_ff;
                  oidx_in = pidx_ff;
                  oown_in = pown_ff;
                  oorg_in = porg_ff;
               end
               pend_in = 1'b1;
               pidx_in = cidx_ff;
               pown_in = cown_ff;
               porg_in = corg_ff;
               taken_in[cidx_ff] = 1'b1;
               pwe = 1'b1;
               owe = 1'b1;
               sel_in = sel_ff + SEL_W'(1);
               prog_in = 1'b1;
               state_in = (sel_ff + SEL_W'(1) >= glim) ? S_FINISH : S_NEXT;
            end
         end
         S_NEXT: begin
            if (i_ff + CNT_W'(1) < nown_ff) begin
               i_in = i_ff + CNT_W'(1);
               slot_in = (CNT_W'(slot_ff) + CNT_W'(1) == nown_ff) ? '0
                                                                  : slot_ff + JIDX_W'(1);
               state_in = S_OWN_RD;
            end else if (prog_ff) begin
               state_in = S_P_START;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (out_free) begin
               ov_in = 1'b1;
               olast_in = 1'b1;
               oovf_in = ovf_ff;
               onone_in = !pend_ff;
               oidx_in = pend_ff ? pidx_ff : '0;
               oown_in = pend_ff ? pown_ff : '0;
               oorg_in = pend_ff ? porg_ff : '0;
               if (nown_ff != '0) begin
                  rr_in = (CNT_W'(off_ff) + CNT_W'(1) == nown_ff) ? '0 : off_ff + JIDX_W'(1);
               end
               cnt_in = '0;
               nown_in = '0;
               sel_in = '0;
               hprev_in = 1'b0;
               pend_in = 1'b0;
               taken_in = '0;
               state_in = S_LOAD;
            end
         end
         default: state_in = S_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
         cnt_ff <= '0;
         nown_ff <= '0;
         rr_ff <= '0;
         sel_ff <= '0;
         ovf_ff <= 1'b0;
         hprev_ff <= 1'b0;
         taken_ff <= '0;
         pend_ff <= 1'b0;
         ov_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         nown_ff <= nown_in;
         rr_ff <= rr_in;
         sel_ff <= sel_in;
         ovf_ff <= (state_ff == S_FINISH && out_free) ? 1'b0 : ovf_in;
         hprev_ff <= hprev_in;
         taken_ff <= taken_in;
         pend_ff <= pend_in;
         ov_ff <= ov_in;
      end
      scan_ff <= scan_in;   i_ff <= i_in;     off_ff <= off_in;   slot_ff <= slot_in;
      k_ff <= k_in;         ocnt_ff <= ocnt_in; prog_ff <= prog_in; pub_ff <= pub_in;
      bfound_ff <= bfound_in; prev_ff <= prev_in; best_ff <= best_in; cur_ff <= cur_in;
      corg_ff <= corg_in;   cown_ff <= cown_in; cidx_ff <= cidx_in;
      pidx_ff <= pidx_in;   pown_ff <= pown_in; porg_ff <= porg_in;
      onone_ff <= onone_in; olast_ff <= olast_in; oovf_ff <= oovf_in;
      oidx_ff <= oidx_in;   oown_ff <= oown_in; oorg_ff <= oorg_in;
   end

   // table memories
   always_ff @(posedge clock) begin
      if (jwe) begin
         job_mem[cnt_ff[JIDX_W-1:0]] <= '{cls: in_entry.cls, owner: in_entry.owner,
                                          origin: in_entry.origin};
      end
      q_job <= job_mem[scan_ff[JIDX_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (owe) begin
         owner_mem[owa] <= owd;
      end
      q_own <= owner_mem[slot_ff];
   end

   always_ff @(posedge clock) begin
      if (pwe) begin
         porg_mem[sel_ff[PSW-1:0]] <= corg_ff;
      end
      q_org <= porg_mem[k_ff[PSW-1:0]];
   end

   assign out_valid    = ov_ff;
   assign out_index    = 6'(oidx_ff);
   assign out_owner    = oown_ff;
   assign out_origin   = oorg_ff;
   assign out_none     = onone_ff;
   assign out_overflow = oovf_ff;
   assign out_last     = olast_ff;

endmodule

>>> verif/fair_job_batch_selector_core_tb.sv
// fair_job_batch_selector_core_tb: self-checking bench for the fair job batch selector
// loads job batches, predicts the fair selection per batch and checks every result transfer
// depends on fjbs_pkg and fair_job_batch_selector_core
module fair_job_batch_selector_core_tb
   import fjbs_pkg::*;
();

   localparam int NJOB = 64;
   localparam int NSEL = 16;
   localparam int CYCLE_LIMIT = 3000000;

   typedef struct {
      logic [3:0]  state;
      logic [31:0] owner;
      logic [31:0] origin;
      logic        last;
   } job_item_type;

   typedef struct {
      logic [5:0]  index;
      logic [31:0] owner;
      logic [31:0] origin;
      logic        none;
      logic        ovf;
      logic        last;
   } pick_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [71:0] req_tdata = '0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [4:0]  csr_data = '0;

   fair_job_batch_selector_core dut (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // predictor state
   logic [4:0]  lim_global, lim_owner, lim_origin;
   logic [31:0] tbl_owner [NJOB];
   logic [31:0] tbl_origin[NJOB];
   logic [1:0]  tbl_cls   [NJOB];
   bit          tbl_taken [NJOB];
   int          load_count;
   int          rr_pos;
   bit          dropped;

   job_item_type pending_jobs[$];
   pick_type     expected_picks[$];
   int        errors = 0;
   bit        hold_off = 0;
   int        hold_len = 0;
   longint    cycles = 0;

   function automatic int origin_taken(logic [31:0] org);
      int n = 0;
      for (int i = 0; i < load_count; i++)
         if (tbl_taken[i] && tbl_origin[i] == org) n++;
      return n;
   endfunction

   function automatic int first_job(logic [31:0] own);
      logic [1:0] c;
      for (int p = 0; p < 2; p++) begin
         c = (p == 0) ? CLS_ACTIVE : CLS_PUBLISHED;
         for (int i = 0; i < load_count; i++) begin
            if (tbl_cls[i] != c || tbl_taken[i] || tbl_owner[i] != own) continue;
            if (origin_taken(tbl_origin[i]) < lim_origin) return i;
         end
      end
      return -1;
   endfunction

   task automatic predict_job(job_item_type it);
      logic [31:0] owners[$];
      int          usage[NJOB];
      int          picks[$];
      int          nown, glim, slot, jb, ins;
      bit          found, moved;
      pick_type    r;
      if (load_count < NJOB) begin
         tbl_owner[load_count]  = it.owner;
         tbl_origin[load_count] = it.origin;
         tbl_cls[load_count] = (it.state <= ST_ABORTING) ? CLS_ACTIVE :
                               (it.state == ST_PUBLISHED) ? CLS_PUBLISHED : CLS_DROP;
         load_count++;
      end else dropped = 1;
      if (!it.last) return;
      for (int i = 0; i < load_count; i++) begin
         tbl_taken[i] = 0;
         if (tbl_cls[i] == CLS_DROP) continue;
         found = 0;
         foreach (owners[j]) if (owners[j] == tbl_owner[i]) found = 1;
         if (found) continue;
         ins = owners.size();
         for (int j = 0; j < owners.size(); j++)
            if (owners[j] > tbl_owner[i]) begin
               ins = j;
               break;
            end
         owners.insert(ins, tbl_owner[i]);
      end
      nown = owners.size();
      foreach (usage[i]) usage[i] = 0;
      if (nown > 0) rr_pos = rr_pos % nown;
      glim = (lim_global < NSEL) ? lim_global : NSEL;
      moved = 1;
      while (moved && picks.size() < glim) begin
         moved = 0;
         for (int i = 0; i < nown; i++) begin
            slot = (i + rr_pos) % nown;
            if (usage[slot] >= lim_owner) continue;
            jb = first_job(owners[slot]);
            if (jb < 0) continue;
            tbl_taken[jb] = 1;
            usage[slot]++;
            picks = {picks, jb};
            moved = 1;
            if (picks.size() >= glim) break;
         end
      end
      if (nown > 0) rr_pos = (rr_pos + 1) % nown;
      if (picks.size() == 0) begin
         r = '{index: 0, owner: 0, origin: 0, none: 1, ovf: dropped, last: 1};
         expected_picks = {expected_picks, r};
      end else
         foreach (picks[i]) begin
            r.index = picks[i][5:0];
            r.owner = tbl_owner[picks[i]];
            r.origin = tbl_origin[picks[i]];
            r.none = 0;
            r.ovf = dropped;
            r.last = (i == picks.size() - 1);
            expected_picks = {expected_picks, r};
         end
      load_count = 0;
      dropped = 0;
   endtask

   // driver: bursts and gaps
   int burst_left = 0, gap_left = 0;
   bit hold_sender = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            predict_job(pending_jobs.pop_front());
         end
         if (req_tvalid && !req_tready) begin
         end else if (pending_jobs.size() > 0 && !hold_sender && gap_left == 0) begin
            req_tvalid <= 1'b1;
            req_tdata  <= {4'b0, pending_jobs[0].origin, pending_jobs[0].owner,
                           pending_jobs[0].state};
            req_tlast  <= pending_jobs[0].last;
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 20);
            end
            burst_left--;
            if (burst_left == 0 && $urandom_range(0, 2) != 0) gap_left = $urandom_range(1, 12);
         end else begin
            req_tvalid <= 1'b0;
            if (gap_left > 0) gap_left--;
         end
      end
   end

   // receiver stall pattern, with a long hold-off on request
   int stall_mode = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (hold_off) begin
            rsp_tready <= 1'b0;
            hold_len++;
            if (hold_len >= 3000) begin
               hold_off = 0;
               hold_len = 0;
            end
         end else begin
            if ($urandom_range(0, 199) == 0) stall_mode = $urandom_range(0, 2);
            case (stall_mode)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= ($urandom_range(0, 3) != 0);
               default: rsp_tready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   // monitor
   pick_type got, want;
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = '{index: rsp_tdata[5:0], owner: rsp_tdata[37:6], origin: rsp_tdata[69:38],
                 none: rsp_tuser[0], ovf: rsp_tuser[1], last: rsp_tlast};
         if (expected_picks.size() == 0) begin
            $error("result transfer with nothing expected");
            errors++;
         end else begin
            want = expected_picks.pop_front();
            if (got.index != want.index) begin
               $error("job_index exp %0d got %0d", want.index, got.index); errors++;
            end
            if (got.owner != want.owner) begin
               $error("sel_owner exp %h got %h", want.owner, got.owner); errors++;
            end
            if (got.origin != want.origin) begin
               $error("sel_origin exp %h got %h", want.origin, got.origin); errors++;
            end
            if (got.none != want.none) begin
               $error("none_selected exp %0d got %0d", want.none, got.none); errors++;
            end
            if (got.ovf != want.ovf) begin
               $error("overflow exp %0d got %0d", want.ovf, got.ovf); errors++;
            end
            if (got.last != want.last) begin
               $error("last_result exp %0d got %0d", want.last, got.last); errors++;
            end
         end
      end
   end

   task automatic write_reg(logic [1:0] idx, logic [4:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         REG_GLOBAL_LIMIT: lim_global = val;
         REG_OWNER_LIMIT:  lim_owner = val;
         default:          lim_origin = val;
      endcase
   endtask

   task automatic wait_idle();
      while (pending_jobs.size() > 0 || req_tvalid || expected_picks.size() > 0)
         @(posedge clock);
      repeat (3000) @(posedge clock);
   endtask

   task automatic add_job(logic [3:0] st, logic [31:0] own, logic [31:0] org, bit lst);
      job_item_type it;
      it = '{state: st, owner: own, origin: org, last: lst};
      pending_jobs = {pending_jobs, it};
   endtask

   // random batch: small owner and origin pools so limits matter
   task automatic add_batch(int n, bit wide);
      logic [31:0] opool[4], gpool[4];
      logic [3:0]  st;
      for (int i = 0; i < 4; i++) begin
         opool[i] = wide ? $urandom : $urandom_range(0, 7);
         gpool[i] = wide ? $urandom : $urandom_range(0, 7);
      end
      for (int i = 0; i < n; i++) begin
         st = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(0, 8));
         add_job(st, opool[$urandom_range(0, 3)], gpool[$urandom_range(0, 3)], i == n - 1);
      end
   endtask

   initial begin
      lim_global = 16; lim_owner = 4; lim_origin = 4;
      load_count = 0; rr_pos = 0; dropped = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: field extremes, every state, empty and single batches
      add_job(4'd7, 32'h0, 32'h0, 1);
      add_job(4'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1);
      for (int s = 0; s < 16; s++) add_job(4'(s), 32'(s % 3), 32'(s % 2), s == 15);
      add_job(4'd6, 32'h5, 32'h1, 0);
      add_job(4'd0, 32'h5, 32'h1, 1);
      wait_idle();

      // overflow: a full table plus dropped jobs, last on a dropped one
      add_batch(70, 0);
      wait_idle();

      // zero limits and extremes
      write_reg(REG_GLOBAL_LIMIT, 5'd0);
      add_batch(6, 0);
      wait_idle();
      write_reg(REG_GLOBAL_LIMIT, 5'd31);
      write_reg(REG_OWNER_LIMIT, 5'd0);
      add_batch(6, 0);
      wait_idle();
      write_reg(REG_OWNER_LIMIT, 5'd31);
      write_reg(REG_ORIGIN_LIMIT, 5'd0);
      add_batch(6, 0);
      wait_idle();
      write_reg(REG_ORIGIN_LIMIT, 5'd1);
      write_reg(REG_OWNER_LIMIT, 5'd1);
      add_batch(20, 0);
      wait_idle();

      // random phases; long receiver hold-off in the first one
      for (int ph = 0; ph < 4; ph++) begin
         write_reg(REG_GLOBAL_LIMIT, 5'($urandom_range(1, 20)));
         write_reg(REG_OWNER_LIMIT, 5'($urandom_range(1, 16)));
         write_reg(REG_ORIGIN_LIMIT, 5'($urandom_range(1, 16)));
         if (ph == 0) hold_off = 1;
         for (int b = 0; b < 10; b++) begin
            add_batch($urandom_range(1, ($urandom_range(0, 15) == 0) ? 66 : 12), b[0]);
         end
         if (ph == 2) begin
            while (expected_picks.size() == 0 && pending_jobs.size() > 0) @(posedge clock);
            hold_sender = 1;
            while (expected_picks.size() > 0) @(posedge clock);
            hold_sender = 0;
         end
         wait_idle();
      end
      write_reg(REG_GLOBAL_LIMIT, 5'd16);
      write_reg(REG_OWNER_LIMIT, 5'd4);
      write_reg(REG_ORIGIN_LIMIT, 5'd4);
      for (int b = 0; b < 6; b++) add_batch($urandom_range(1, 12), 0);
      wait_idle();

      if (errors == 0 && expected_picks.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
